// File: rtl/wsfr_pkg.sv
// ----------------------------------------------------------------------------
// wsfr_pkg
// Codes and fixed widths of the websocket frame receiver: parser phases,
// frame opcodes, delivered message kinds and header length codes.
// ----------------------------------------------------------------------------
package wsfr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned CODE_W  = 4;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned HCNT_W  = 3;
    localparam int unsigned KEY_W   = 32;

    typedef logic [PHASE_W-1:0] t_phase;
    typedef logic [CODE_W-1:0]  t_code;
    typedef logic [KIND_W-1:0]  t_kind;
    typedef logic [HCNT_W-1:0]  t_hcnt;

    // parser phases
    localparam t_phase PH_HDR0   = 3'd0;
    localparam t_phase PH_HDR1   = 3'd1;
    localparam t_phase PH_EXT    = 3'd2;
    localparam t_phase PH_KEY    = 3'd3;
    localparam t_phase PH_DATA   = 3'd4;
    localparam t_phase PH_CLOSED = 3'd5;

    // frame opcodes
    localparam t_code OP_CONT  = 4'h0;
    localparam t_code OP_TEXT  = 4'h1;
    localparam t_code OP_CLOSE = 4'h8;
    localparam t_code OP_PING  = 4'h9;

    // delivered message kinds
    localparam t_kind KIND_TEXT  = 2'd0;
    localparam t_kind KIND_PING  = 2'd1;
    localparam t_kind KIND_CLOSE = 2'd2;

    // 7-bit length codes that announce an extension
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // remaining extension / key bytes after the first one
    localparam t_hcnt HCNT_EXT16 = 3'd1;
    localparam t_hcnt HCNT_EXT64 = 3'd7;
    localparam t_hcnt HCNT_KEY   = 3'd3;

endpackage

// File: rtl/websocket_frame_receiver.sv
// ----------------------------------------------------------------------------
// websocket_frame_receiver
// Parses a websocket byte stream and delivers unmasked text and ping payload,
// message end marks and a single close event.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready / i_rx_byte) takes one stream byte per
//   request. Output channel (o_valid / i_ready) carries o_data_byte,
//   o_has_byte, o_msg_kind and o_msg_last; zero or one result per byte.
//   Each byte is parsed in the cycle it is accepted and its result sits in
//   the output register from the next cycle on. One byte is taken every
//   clock unless a held result stalls; the output register alone sets the
//   rate, and it is refilled in the same cycle it is drained, so o_ready
//   stays high while i_ready is high. When the receiver stalls with a
//   result held, o_ready drops and the held result stays unchanged until taken.
//   A fin text or ping frame with no payload yields one item with o_has_byte
//   low. A completed close frame yields one close item; every later byte is
//   accepted and dropped until reset.
//   Reset (synchronous, active low) returns the parser to the first header
//   byte, clears the remembered fragment opcode and empties the output.
// ----------------------------------------------------------------------------
module websocket_frame_receiver
    import wsfr_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic              o_has_byte,
    output logic [KIND_W-1:0] o_msg_kind,
    output logic              o_msg_last
);

    typedef logic [LENGTH_BITS-1:0] t_len;

    // parser state
    t_phase           r_phase,     n_phase;
    logic             r_fin,       n_fin;
    t_code            r_code,      n_code;
    logic             r_masked,    n_masked;
    t_hcnt            r_hcnt,      n_hcnt;
    t_len             r_left,      n_left;
    logic [KEY_W-1:0] r_key,       n_key;
    logic [1:0]       r_key_pos,   n_key_pos;
    t_code            r_rem_code,  n_rem_code;
    logic             r_pending,   n_pending;

    // output register
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_data,  n_out_data;
    logic              r_out_has,   n_out_has;
    t_kind             r_out_kind,  n_out_kind;
    logic              r_out_last,  n_out_last;

    logic              w_accept;
    logic              w_take;
    t_code             w_force;
    logic [BYTE_W-1:0] w_key_byte;
    logic [BYTE_W-1:0] w_plain;
    t_len              w_left_dec;
    logic              w_after_len;
    logic              w_start;
    logic              w_end;
    logic              w_empty;

    assign w_take   = r_out_valid & i_ready;
    assign o_ready  = ~r_out_valid | i_ready;
    assign w_accept = i_valid & o_ready;

    // opcode in force for the current frame
    assign w_force = (!r_fin || r_pending) ? r_rem_code : r_code;

    always_comb begin
        case (r_key_pos)
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            default: w_key_byte = r_key[7:0];
        endcase
    end

    assign w_plain    = r_masked ? (i_rx_byte ^ w_key_byte) : i_rx_byte;
    assign w_left_dec = r_left - t_len'(1);

    always_comb begin
        n_phase     = r_phase;
        n_fin       = r_fin;
        n_code      = r_code;
        n_masked    = r_masked;
        n_hcnt      = r_hcnt;
        n_left      = r_left;
        n_key       = r_key;
        n_key_pos   = r_key_pos;
        n_rem_code  = r_rem_code;
        n_pending   = r_pending;
        n_out_valid = r_out_valid & ~w_take;
        n_out_data  = r_out_data;
        n_out_has   = r_out_has;
        n_out_kind  = r_out_kind;
        n_out_last  = r_out_last;
        w_after_len = 1'b0;
        w_start     = 1'b0;
        w_end       = 1'b0;
        w_empty     = 1'b0;

        if (w_accept) begin
            case (r_phase)
                PH_HDR0: begin
                    n_fin  = i_rx_byte[7];
                    n_code = i_rx_byte[CODE_W-1:0];
                    if (!i_rx_byte[7] && i_rx_byte[CODE_W-1:0] != OP_CONT) begin
                        n_rem_code = i_rx_byte[CODE_W-1:0];
                    end
                    n_phase = PH_HDR1;
                end
                PH_HDR1: begin
                    n_masked = i_rx_byte[7];
                    if (i_rx_byte[6:0] == LEN_EXT16 || i_rx_byte[6:0] == LEN_EXT64) begin
                        n_left  = '0;
                        n_hcnt  = (i_rx_byte[6:0] == LEN_EXT16) ? HCNT_EXT16 : HCNT_EXT64;
                        n_phase = PH_EXT;
                    end else begin
                        n_left      = t_len'(i_rx_byte[6:0]);
                        w_after_len = 1'b1;
                    end
                end
                PH_EXT: begin
                    n_left = {r_left[LENGTH_BITS-BYTE_W-1:0], i_rx_byte};
                    if (r_hcnt != '0) begin
                        n_hcnt = r_hcnt - t_hcnt'(1);
                    end else begin
                        w_after_len = 1'b1;
                    end
                end
                PH_KEY: begin
                    n_key = {r_key[KEY_W-BYTE_W-1:0], i_rx_byte};
                    if (r_hcnt != '0) begin
                        n_hcnt = r_hcnt - t_hcnt'(1);
                    end else begin
                        w_start = 1'b1;
                    end
                end
                PH_DATA: begin
                    n_key_pos = r_key_pos + 2'd1;
                    n_left    = w_left_dec;
                    if (!r_fin) begin
                        n_pending = 1'b1;
                    end
                    if (w_force == OP_TEXT || w_force == OP_PING) begin
                        n_out_valid = 1'b1;
                        n_out_data  = w_plain;
                        n_out_has   = 1'b1;
                        n_out_kind  = (w_force == OP_PING) ? KIND_PING : KIND_TEXT;
                        n_out_last  = r_fin && (w_left_dec == '0);
                    end
                    if (w_left_dec == '0) begin
                        w_end = 1'b1;
                    end
                end
                default: begin
                    // closed: drop every byte
                end
            endcase

            if (w_after_len) begin
                if (n_masked) begin
                    n_hcnt  = HCNT_KEY;
                    n_key   = '0;
                    n_phase = PH_KEY;
                end else begin
                    w_start = 1'b1;
                end
            end

            if (w_start) begin
                n_key_pos = 2'd0;
                if (n_left == '0) begin
                    w_end   = 1'b1;
                    w_empty = 1'b1;
                end else begin
                    n_phase = PH_DATA;
                end
            end

            if (w_end) begin
                n_phase = PH_HDR0;
                if (n_fin) begin
                    n_pending = 1'b0;
                    if (w_force == OP_CLOSE) begin
                        n_phase     = PH_CLOSED;
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                        n_out_has   = 1'b0;
                        n_out_kind  = KIND_CLOSE;
                        n_out_last  = 1'b1;
                    end else if (w_empty && (w_force == OP_TEXT || w_force == OP_PING)) begin
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                        n_out_has   = 1'b0;
                        n_out_kind  = (w_force == OP_PING) ? KIND_PING : KIND_TEXT;
                        n_out_last  = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR0;
            r_fin       <= 1'b0;
            r_code      <= OP_CONT;
            r_masked    <= 1'b0;
            r_hcnt      <= '0;
            r_left      <= '0;
            r_key       <= '0;
            r_key_pos   <= 2'd0;
            r_rem_code  <= OP_CONT;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_fin       <= n_fin;
            r_code      <= n_code;
            r_masked    <= n_masked;
            r_hcnt      <= n_hcnt;
            r_left      <= n_left;
            r_key       <= n_key;
            r_key_pos   <= n_key_pos;
            r_rem_code  <= n_rem_code;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_has  <= n_out_has;
        r_out_kind <= n_out_kind;
        r_out_last <= n_out_last;
    end

    assign o_valid     = r_out_valid;
    assign o_data_byte = r_out_data;
    assign o_has_byte  = r_out_has;
    assign o_msg_kind  = r_out_kind;
    assign o_msg_last  = r_out_last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_closed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_CLOSED |=> r_phase == PH_CLOSED)
        else $error("parser left the closed phase");

    a_close_event_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_msg_kind == KIND_CLOSE) |-> (!o_has_byte && o_msg_last))
        else $error("close event carries payload or lacks end mark");

    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_byte) |-> (o_msg_last && o_data_byte == '0))
        else $error("item without payload is not a clean message end");

    a_key_needs_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_KEY |-> r_masked)
        else $error("mask key read for an unmasked frame");

    a_close_enters_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_valid && !r_out_valid && n_out_kind == KIND_CLOSE)
            |=> r_phase == PH_CLOSED)
        else $error("close event without entering the closed phase");

endmodule
